// File: hdl/threshold_key_debounce_autorepeat_macros.svh
// Assertion macros shared by the threshold key RTL.
`ifndef THRESHOLD_KEY_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define THRESHOLD_KEY_DEBOUNCE_AUTOREPEAT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TKDA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TKDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tkda_pkg.sv
// Package: constants, codes and types of the threshold key block.
`timescale 1ns / 1ps

package tkda_pkg;

    localparam int TICK_BITS    = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int FIELD_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CMP_BITS     = (TICK_BITS > FIELD_BITS) ? TICK_BITS : FIELD_BITS;

    localparam logic [FIELD_BITS-1:0] TIMER_OFF = {FIELD_BITS{1'b1}};

    localparam logic signed [FIELD_BITS-1:0] RST_LOW_THR  = FIELD_BITS'(8000);
    localparam logic signed [FIELD_BITS-1:0] RST_HIGH_THR = FIELD_BITS'(24000);
    localparam logic [FIELD_BITS-1:0]        RST_DEBOUNCE = FIELD_BITS'(20);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_HWAIT  = 3'd1,
        MODE_HPRESS = 3'd2,
        MODE_HREP   = 3'd3,
        MODE_LWAIT  = 3'd4,
        MODE_LPRESS = 3'd5,
        MODE_LREP   = 3'd6
    } mode_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LOW_THR  = 3'd0,
        REG_HIGH_THR = 3'd1,
        REG_DEBOUNCE = 3'd2,
        REG_DELAY    = 3'd3,
        REG_INTERVAL = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] low_thr;
        logic signed [FIELD_BITS-1:0] high_thr;
        logic [FIELD_BITS-1:0]        debounce;
        logic [FIELD_BITS-1:0]        delay;
        logic [FIELD_BITS-1:0]        interval;
    } cfg_t;

    typedef struct packed {
        logic hi;
        logic lo;
        logic ctr;
    } class_t;

    typedef struct packed {
        logic  pulse_high;
        logic  pulse_low;
        mode_t mode;
    } res_t;

endpackage

// File: hdl/tkda_cfg.sv
// Configuration register file: thresholds and timer limits.
`timescale 1ns / 1ps

module tkda_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tkda_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tkda_pkg::FIELD_BITS-1:0]   cfg_data,
    output tkda_pkg::cfg_t                    cfg
);

    tkda_pkg::cfg_t cfg_reg;
    tkda_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (tkda_pkg::reg_idx_t'(cfg_index))
                tkda_pkg::REG_LOW_THR:  cfg_next.low_thr  = cfg_data;
                tkda_pkg::REG_HIGH_THR: cfg_next.high_thr = cfg_data;
                tkda_pkg::REG_DEBOUNCE: cfg_next.debounce = cfg_data;
                tkda_pkg::REG_DELAY:    cfg_next.delay    = cfg_data;
                tkda_pkg::REG_INTERVAL: cfg_next.interval = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_thr  <= tkda_pkg::RST_LOW_THR;
            cfg_reg.high_thr <= tkda_pkg::RST_HIGH_THR;
            cfg_reg.debounce <= tkda_pkg::RST_DEBOUNCE;
            cfg_reg.delay    <= tkda_pkg::TIMER_OFF;
            cfg_reg.interval <= tkda_pkg::TIMER_OFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/tkda_class.sv
// Sample classifier: high, low or centre against the two thresholds.
`timescale 1ns / 1ps

module tkda_class (
    input  logic [tkda_pkg::FIELD_BITS-1:0] sample,
    input  tkda_pkg::cfg_t                  cfg,
    output tkda_pkg::class_t                cls
);

    logic signed [tkda_pkg::FIELD_BITS-1:0] samp_ext;

    assign samp_ext = tkda_pkg::FIELD_BITS'(signed'(sample[tkda_pkg::SAMPLE_BITS-1:0]));

    assign cls.hi  = samp_ext >= cfg.high_thr;
    assign cls.lo  = samp_ext <= cfg.low_thr;
    assign cls.ctr = (cfg.low_thr < samp_ext) && (samp_ext < cfg.high_thr);

endmodule

// File: hdl/tkda_step.sv
// Key state machine and tick counter; one step per transferred sample.
`timescale 1ns / 1ps
`include "threshold_key_debounce_autorepeat_macros.svh"

module tkda_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  tkda_pkg::class_t cls,
    input  tkda_pkg::cfg_t   cfg,
    output tkda_pkg::res_t   res
);

    tkda_pkg::mode_t                  mode_reg;
    tkda_pkg::mode_t                  mode_next;
    logic [tkda_pkg::TICK_BITS-1:0]   ticks_reg;
    logic [tkda_pkg::TICK_BITS-1:0]   ticks_next;
    logic [tkda_pkg::TICK_BITS-1:0]   elapsed;
    logic [tkda_pkg::CMP_BITS-1:0]    elapsed_w;
    logic                             moved;
    logic                             hit_deb;
    logic                             hit_del;
    logic                             hit_int;

    // saturating tick count
    assign elapsed   = (&ticks_reg) ? ticks_reg : ticks_reg + 1'b1;
    assign elapsed_w = tkda_pkg::CMP_BITS'(elapsed);

    assign hit_deb = elapsed_w >= tkda_pkg::CMP_BITS'(cfg.debounce);
    assign hit_del = (cfg.delay != tkda_pkg::TIMER_OFF)
                     && (elapsed_w >= tkda_pkg::CMP_BITS'(cfg.delay));
    assign hit_int = (cfg.interval != tkda_pkg::TIMER_OFF)
                     && (elapsed_w >= tkda_pkg::CMP_BITS'(cfg.interval));

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        moved     = 1'b0;
        unique case (mode_reg)
            tkda_pkg::MODE_IDLE:
            begin
                priority if (cls.hi)
                begin
                    mode_next = tkda_pkg::MODE_HWAIT;
                    moved     = 1'b1;
                end
                else if (cls.lo)
                begin
                    mode_next = tkda_pkg::MODE_LWAIT;
                    moved     = 1'b1;
                end
                else
                begin
                    mode_next = mode_reg;
                    moved     = 1'b0;
                end
            end
            tkda_pkg::MODE_HWAIT, tkda_pkg::MODE_HPRESS, tkda_pkg::MODE_HREP:
            begin
                priority if (cls.ctr || cls.lo)
                begin
                    mode_next = tkda_pkg::MODE_IDLE;
                    moved     = 1'b1;
                end
                else if (mode_reg == tkda_pkg::MODE_HWAIT && hit_deb)
                begin
                    mode_next = tkda_pkg::MODE_HPRESS;
                    moved     = 1'b1;
                end
                else if (mode_reg == tkda_pkg::MODE_HPRESS && hit_del)
                begin
                    mode_next = tkda_pkg::MODE_HREP;
                    moved     = 1'b1;
                end
                else if (mode_reg == tkda_pkg::MODE_HREP && hit_int)
                begin
                    mode_next = tkda_pkg::MODE_HREP;
                    moved     = 1'b1;
                end
                else
                begin
                    mode_next = mode_reg;
                    moved     = 1'b0;
                end
            end
            tkda_pkg::MODE_LWAIT, tkda_pkg::MODE_LPRESS, tkda_pkg::MODE_LREP:
            begin
                priority if (cls.ctr || cls.hi)
                begin
                    mode_next = tkda_pkg::MODE_IDLE;
                    moved     = 1'b1;
                end
                else if (mode_reg == tkda_pkg::MODE_LWAIT && hit_deb)
                begin
                    mode_next = tkda_pkg::MODE_LPRESS;
                    moved     = 1'b1;
                end
                else if (mode_reg == tkda_pkg::MODE_LPRESS && hit_del)
                begin
                    mode_next = tkda_pkg::MODE_LREP;
                    moved     = 1'b1;
                end
                else if (mode_reg == tkda_pkg::MODE_LREP && hit_int)
                begin
                    mode_next = tkda_pkg::MODE_LREP;
                    moved     = 1'b1;
                end
                else
                begin
                    mode_next = mode_reg;
                    moved     = 1'b0;
                end
            end
            default:
            begin
                mode_next = tkda_pkg::MODE_IDLE;
                moved     = 1'b1;
            end
        endcase
    end

    // outputs: a pulse on every entry to a pressed or repeating mode
    always_comb
    begin
        res.mode       = mode_next;
        res.pulse_high = moved && (mode_next == tkda_pkg::MODE_HPRESS
                                   || mode_next == tkda_pkg::MODE_HREP);
        res.pulse_low  = moved && (mode_next == tkda_pkg::MODE_LPRESS
                                   || mode_next == tkda_pkg::MODE_LREP);
    end

    assign ticks_next = moved ? '0 : elapsed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tkda_pkg::MODE_IDLE;
            ticks_reg <= '0;
        end
        else if (adv)
        begin
            mode_reg  <= mode_next;
            ticks_reg <= ticks_next;
        end
    end

    `TKDA_ASSERT_IMPL(a_one_side, 1'b1, !(res.pulse_high && res.pulse_low), "both pulses set")
    `TKDA_ASSERT_NEXT(a_pulse_clears, adv && (res.pulse_high || res.pulse_low), ticks_reg == '0, "tick count not cleared on pulse")
    `TKDA_ASSERT_NEXT(a_hold, !adv, $stable(mode_reg) && $stable(ticks_reg), "state moved without a transfer")

endmodule

// File: hdl/threshold_key_debounce_autorepeat.sv
// Top level: threshold key with debounce and autorepeat.
`timescale 1ns / 1ps
`include "threshold_key_debounce_autorepeat_macros.svh"

// Takes one signed sample per tick and returns one result per sample: a high
// or low press/repeat pulse and the key state after that tick. A sample passes
// an input register and then a result register before its result is on the output;
// one sample is taken every clock while the output is not stalled. The rate is
// set by the update of the state and tick counter between the two registers.
// Registers are written through the plain write port and apply from the next
// sample.
module threshold_key_debounce_autorepeat (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tkda_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tkda_pkg::FIELD_BITS-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tkda_pkg::FIELD_BITS-1:0]   sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              pulse_high,
    output logic                              pulse_low,
    output logic [2:0]                        state_code
);

    tkda_pkg::cfg_t                  cfg;
    tkda_pkg::class_t                cls;
    tkda_pkg::res_t                  res;
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [tkda_pkg::FIELD_BITS-1:0] s1_sample_reg;
    logic                            out_valid_reg;
    tkda_pkg::res_t                  out_res_reg;
    logic                            out_ready;
    logic                            in_xfer;
    logic                            adv;

    assign out_ready = !out_valid_reg || !out_stall;
    assign adv       = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_xfer   = in_valid && !in_stall;

    always_comb
    begin
        priority if (in_xfer)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    tkda_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tkda_class u_class (
        .sample (s1_sample_reg),
        .cfg    (cfg),
        .cls    (cls)
    );

    tkda_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .cls   (cls),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_sample_reg <= sample;
        end
        if (adv)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pulse_high = out_res_reg.pulse_high;
    assign pulse_low  = out_res_reg.pulse_low;
    assign state_code = out_res_reg.mode;

    `TKDA_ASSERT_IMPL(a_out_from_s1, $rose(out_valid_reg), $past(s1_valid_reg), "result without a sample")
    `TKDA_ASSERT_NEXT(a_s1_held, s1_valid_reg && !out_ready, s1_valid_reg, "sample dropped under stall")
    `TKDA_ASSERT_NEXT(a_result_held, out_valid_reg && out_stall, $stable(out_res_reg), "stalled result changed")

endmodule

// File: tb/sv/threshold_key_debounce_autorepeat_tb.sv
// Testbench for the threshold key block: scoreboard prediction, random timing and settings.
`timescale 1ns / 1ps

module threshold_key_debounce_autorepeat_tb;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SAMPLE_MIN   = -32768;
    localparam int SAMPLE_MAX   = 32767;
    localparam int LONG_HOLD    = 40;
    localparam int HOLD_OFF     = 64;
    localparam int MAX_PRINTED  = 50;

    localparam logic [tkda_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

    localparam int PICK_HIGH   = 0;
    localparam int PICK_LOW    = 1;
    localparam int PICK_CENTRE = 2;
    localparam int PICK_NOISE  = 3;

    class key_scoreboard;
        logic signed [tkda_pkg::FIELD_BITS-1:0] low_thr;
        logic signed [tkda_pkg::FIELD_BITS-1:0] high_thr;
        logic [tkda_pkg::FIELD_BITS-1:0]        debounce;
        logic [tkda_pkg::FIELD_BITS-1:0]        delay;
        logic [tkda_pkg::FIELD_BITS-1:0]        interval;
        tkda_pkg::mode_t                        key_mode;
        logic [tkda_pkg::TICK_BITS-1:0]         hold_ticks;
        tkda_pkg::res_t                         pending[$];
        int                                     errors;
        int                                     samples;
        int                                     results;
        int                                     high_pulses;
        int                                     low_pulses;

        function new();
            low_thr     = tkda_pkg::RST_LOW_THR;
            high_thr    = tkda_pkg::RST_HIGH_THR;
            debounce    = tkda_pkg::RST_DEBOUNCE;
            delay       = tkda_pkg::TIMER_OFF;
            interval    = tkda_pkg::TIMER_OFF;
            key_mode    = tkda_pkg::MODE_IDLE;
            hold_ticks  = '0;
            errors      = 0;
            samples     = 0;
            results     = 0;
            high_pulses = 0;
            low_pulses  = 0;
        endfunction

        function void set_reg(logic [tkda_pkg::CFG_IDX_BITS-1:0] idx,
                              logic [tkda_pkg::FIELD_BITS-1:0] val);
            case (idx)
                tkda_pkg::REG_LOW_THR:  low_thr = val;
                tkda_pkg::REG_HIGH_THR: high_thr = val;
                tkda_pkg::REG_DEBOUNCE: debounce = val;
                tkda_pkg::REG_DELAY:    delay = val;
                tkda_pkg::REG_INTERVAL: interval = val;
                default: ;
            endcase
        endfunction

        function bit timer_due(logic [tkda_pkg::FIELD_BITS-1:0] limit,
                               logic [tkda_pkg::TICK_BITS-1:0] elapsed,
                               bit can_disable);
            if (can_disable && limit == tkda_pkg::TIMER_OFF)
                return 1'b0;
            return elapsed >= limit;
        endfunction

        function void note_sample(logic [tkda_pkg::FIELD_BITS-1:0] raw);
            logic signed [tkda_pkg::SAMPLE_BITS-1:0] s;
            logic                                    is_hi;
            logic                                    is_lo;
            logic                                    is_ctr;
            logic                                    leave;
            logic                                    moved;
            logic                                    high_side;
            logic [tkda_pkg::TICK_BITS-1:0]          elapsed;
            logic [2:0]                              phase;
            tkda_pkg::mode_t                         nxt;
            tkda_pkg::res_t                          r;
            s       = raw;
            is_hi   = s >= high_thr;
            is_lo   = s <= low_thr;
            is_ctr  = (low_thr < s) && (s < high_thr);
            elapsed = (hold_ticks == {tkda_pkg::TICK_BITS{1'b1}}) ? hold_ticks
                                                                   : hold_ticks + 1'b1;
            nxt     = key_mode;
            moved   = 1'b0;
            case (key_mode)
                tkda_pkg::MODE_IDLE:
                begin
                    if (is_hi)
                    begin
                        nxt   = tkda_pkg::MODE_HWAIT;
                        moved = 1'b1;
                    end
                    else if (is_lo)
                    begin
                        nxt   = tkda_pkg::MODE_LWAIT;
                        moved = 1'b1;
                    end
                end
                tkda_pkg::MODE_HWAIT, tkda_pkg::MODE_HPRESS, tkda_pkg::MODE_HREP,
                tkda_pkg::MODE_LWAIT, tkda_pkg::MODE_LPRESS, tkda_pkg::MODE_LREP:
                begin
                    high_side = key_mode <= tkda_pkg::MODE_HREP;
                    leave     = is_ctr || (high_side ? is_lo : is_hi);
                    phase     = high_side ? 3'(key_mode - tkda_pkg::MODE_HWAIT)
                                          : 3'(key_mode - tkda_pkg::MODE_LWAIT);
                    if (leave)
                    begin
                        nxt   = tkda_pkg::MODE_IDLE;
                        moved = 1'b1;
                    end
                    else if (phase == 3'd0)
                    begin
                        if (timer_due(debounce, elapsed, 1'b0))
                        begin
                            nxt   = tkda_pkg::mode_t'(key_mode + 3'd1);
                            moved = 1'b1;
                        end
                    end
                    else if (phase == 3'd1)
                    begin
                        if (timer_due(delay, elapsed, 1'b1))
                        begin
                            nxt   = tkda_pkg::mode_t'(key_mode + 3'd1);
                            moved = 1'b1;
                        end
                    end
                    else if (timer_due(interval, elapsed, 1'b1))
                    begin
                        nxt   = key_mode;
                        moved = 1'b1;
                    end
                end
                default:
                begin
                    nxt   = tkda_pkg::MODE_IDLE;
                    moved = 1'b1;
                end
            endcase
            r.pulse_high = moved && (nxt == tkda_pkg::MODE_HPRESS || nxt == tkda_pkg::MODE_HREP);
            r.pulse_low  = moved && (nxt == tkda_pkg::MODE_LPRESS || nxt == tkda_pkg::MODE_LREP);
            r.mode       = nxt;
            hold_ticks   = moved ? '0 : elapsed;
            key_mode     = nxt;
            pending.push_back(r);
            samples++;
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTED)
                $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic ph, logic pl, logic [2:0] code);
            tkda_pkg::res_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("result %b/%b/%0d with nothing expected", ph, pl, code));
                return;
            end
            want = pending.pop_front();
            results++;
            if (ph !== want.pulse_high)
                report_mismatch($sformatf("result %0d: pulse_high %b, expected %b",
                                          results, ph, want.pulse_high));
            if (pl !== want.pulse_low)
                report_mismatch($sformatf("result %0d: pulse_low %b, expected %b",
                                          results, pl, want.pulse_low));
            if (code !== want.mode)
                report_mismatch($sformatf("result %0d: state_code %0d, expected %0d",
                                          results, code, want.mode));
            if (want.pulse_high)
                high_pulses++;
            if (want.pulse_low)
                low_pulses++;
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [tkda_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [tkda_pkg::FIELD_BITS-1:0]   cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic [tkda_pkg::FIELD_BITS-1:0]   sample;
    logic                              out_valid;
    logic                              out_stall;
    logic                              pulse_high;
    logic                              pulse_low;
    logic [2:0]                        state_code;

    key_scoreboard sb;
    bit            tx_idle_on = 1'b1;
    bit            rx_idle_on = 1'b1;
    int            rx_hold_cycles = 0;
    int            settings = 0;
    int            cycle_count = 0;

    threshold_key_debounce_autorepeat u_top (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("threshold_key_debounce_autorepeat_tb: done, errors");
            $finish;
        end
    end

    task automatic send_sample(logic [tkda_pkg::FIELD_BITS-1:0] value);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        sample   = value;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(value);
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [tkda_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [tkda_pkg::FIELD_BITS-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic [tkda_pkg::FIELD_BITS-1:0] pick_between(int lo_b, int hi_b);
        return tkda_pkg::FIELD_BITS'(lo_b + int'($urandom_range(0, hi_b - lo_b)));
    endfunction

    function automatic logic [tkda_pkg::FIELD_BITS-1:0] pick_class(int kind);
        int lt;
        int ht;
        int edge_pick;
        lt        = sb.low_thr;
        ht        = sb.high_thr;
        edge_pick = $urandom_range(0, 5);
        if (kind == PICK_HIGH)
            return (edge_pick == 0) ? tkda_pkg::FIELD_BITS'(ht) : pick_between(ht, SAMPLE_MAX);
        if (kind == PICK_LOW)
            return (edge_pick == 0) ? tkda_pkg::FIELD_BITS'(lt) : pick_between(SAMPLE_MIN, lt);
        if (kind == PICK_CENTRE && ht - lt >= 2)
        begin
            if (edge_pick == 0)
                return tkda_pkg::FIELD_BITS'(lt + 1);
            if (edge_pick == 1)
                return tkda_pkg::FIELD_BITS'(ht - 1);
            return pick_between(lt + 1, ht - 1);
        end
        return tkda_pkg::FIELD_BITS'($urandom);
    endfunction

    function automatic logic [tkda_pkg::FIELD_BITS-1:0] pick_timer(bit may_disable);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return may_disable ? tkda_pkg::TIMER_OFF : tkda_pkg::FIELD_BITS'(1);
            2:       return tkda_pkg::FIELD_BITS'(1);
            default: return tkda_pkg::FIELD_BITS'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic random_setting();
        int style;
        int a;
        int b;
        int t;
        style = $urandom_range(0, 5);
        a     = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
        b     = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
        case (style)
            0:
            begin
                a = SAMPLE_MIN;
                b = SAMPLE_MAX;
            end
            1:
            begin
                a = SAMPLE_MAX;
                b = SAMPLE_MIN;
            end
            2: b = a;
            3:
            begin
                // overlapping bands
                if (a < b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            default:
            begin
                if (a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
        endcase
        write_reg(tkda_pkg::REG_LOW_THR, tkda_pkg::FIELD_BITS'(a));
        write_reg(tkda_pkg::REG_HIGH_THR, tkda_pkg::FIELD_BITS'(b));
        write_reg(tkda_pkg::REG_DEBOUNCE, pick_timer(1'b0));
        write_reg(tkda_pkg::REG_DELAY, pick_timer(1'b1));
        write_reg(tkda_pkg::REG_INTERVAL, pick_timer(1'b1));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, tkda_pkg::FIELD_BITS'($urandom));
        settings++;
    endtask

    // mostly held sides with random content, broken by centre and noise
    task automatic random_stretch(int count);
        int sent;
        int kind;
        int run;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                kind = PICK_HIGH;
            else if (kind < 7)
                kind = PICK_LOW;
            else if (kind < 9)
                kind = PICK_CENTRE;
            else
                kind = PICK_NOISE;
            run = (kind == PICK_NOISE) ? $urandom_range(1, 4) : $urandom_range(1, 30);
            if (run > count - sent)
                run = count - sent;
            repeat (run)
            begin
                send_sample(pick_class(kind));
                sent++;
            end
        end
    endtask

    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = rx_idle_on ? $urandom_range(0, 8) : 0;
            if (rx_hold_cycles > 0)
            begin
                n              = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            repeat (n)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(pulse_high, pulse_low, state_code);
        end
    end

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        out_stall = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset thresholds and their boundaries, crossing sides
        send_sample(16'd24000);
        send_sample(16'd8001);
        send_sample(16'd8000);
        send_sample(16'd24000);
        send_sample(16'd23999);
        drain();
        write_reg(tkda_pkg::REG_DEBOUNCE, 16'd1);
        write_reg(tkda_pkg::REG_DELAY, 16'd2);
        write_reg(tkda_pkg::REG_INTERVAL, 16'd0);
        repeat (6) send_sample(16'h7fff);
        repeat (5) send_sample(16'h8000);
        send_sample(16'd8001);
        drain();
        // overlapping thresholds: a sample may be both sides
        write_reg(tkda_pkg::REG_LOW_THR, 16'd100);
        write_reg(tkda_pkg::REG_HIGH_THR, tkda_pkg::FIELD_BITS'(-100));
        send_sample(16'd0);
        send_sample(16'd0);
        send_sample(16'h8000);
        send_sample(16'd0);
        send_sample(16'h7fff);
        send_sample(16'h7fff);

        for (int p = 0; p < 10; p++)
        begin
            drain();
            random_setting();
            tx_idle_on = (p != 3 && p != 6);
            rx_idle_on = (p != 3);
            if (p == 6)
                rx_hold_cycles = HOLD_OFF;
            random_stretch(50);
        end

        // largest debounce: a held press that never fires
        drain();
        write_reg(tkda_pkg::REG_LOW_THR, tkda_pkg::FIELD_BITS'(-16000));
        write_reg(tkda_pkg::REG_HIGH_THR, 16'd16000);
        write_reg(tkda_pkg::REG_DEBOUNCE, 16'hffff);
        write_reg(tkda_pkg::REG_DELAY, tkda_pkg::TIMER_OFF);
        write_reg(tkda_pkg::REG_INTERVAL, 16'd0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (LONG_HOLD) send_sample(pick_class(PICK_HIGH));
        drain();
        write_reg(tkda_pkg::REG_DELAY, 16'hfffe);
        repeat (4) send_sample(pick_class(PICK_HIGH));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        drain();
        repeat (10) @(posedge clk);

        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
        $display("Covered %0d samples and %0d checked results over %0d random settings,",
                 sb.samples, sb.results, settings);
        $display("with %0d high and %0d low pulses, a long output hold-off and a held press.",
                 sb.high_pulses, sb.low_pulses);
        if (sb.errors == 0)
            $display("threshold_key_debounce_autorepeat_tb: done, clean");
        else
            $display("threshold_key_debounce_autorepeat_tb: done, errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/tkda_pkg.sv
hdl/tkda_cfg.sv
hdl/tkda_class.sv
hdl/tkda_step.sv
hdl/threshold_key_debounce_autorepeat.sv
tb/sv/threshold_key_debounce_autorepeat_tb.sv
